@@ sv/scfp_pkg.sv @@
// Shared definitions for the serial command frame parser.
// Holds the frame geometry, character codes, command kinds and the hex digit decoder.
// No dependencies.
`default_nettype none

package scfp_pkg;

  localparam int unsigned FRAME_LEN = 12;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_START = 8'h2A;  // '*'
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_THREE = 8'h33;

  // Positions within the frame store.
  localparam logic [IDX_W-1:0] POS_FIRST_DIGIT = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_SP_LAST     = IDX_W'(10);
  localparam logic [IDX_W-1:0] POS_TL_LAST     = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_LAST        = IDX_W'(FRAME_LEN - 1);

  typedef enum logic [1:0] {
    KIND_SP = 2'd0,
    KIND_TL = 2'd1,
    KIND_TT = 2'd2
  } cmd_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_HEX   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  // Bit 4 flags a valid digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, c[3:0]};
      [8'h41:8'h46],
      [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/serial_command_frame_parser.sv @@
// Serial command frame parser: top level.
// Depends on scfp_pkg for character codes, states and the hex digit decoder.
// Contains the frame store, the frame checker and the serial hex accumulator.
`default_nettype none

// Each character transfer is stored in a 12-byte frame store; a '#' or a full
// store closes the frame. A closing character is followed by a frame check,
// then the hex digits are shifted one by one, four bits each, into a 32-bit
// accumulator (eight digits for a sample period, two for a trigger level, none
// for a trigger type), then the output register is loaded, waiting while a
// result is still held at the output. The store is never cleared between
// frames, so bytes left by earlier frames take part in the check. Results
// appear with the command kind on tuser and the value on tdata.
module serial_command_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_char
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] cmd_value
  output logic [1:0]       m_axis_tuser_o    // [1:0] cmd_kind
);
  import scfp_pkg::*;

  state_e           state_q, state_d;
  logic [7:0]       store_q [FRAME_LEN];
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] dig_idx_q, dig_idx_d;
  logic [IDX_W-1:0] last_idx_q, last_idx_d;
  logic [31:0]      acc_q, acc_d;
  cmd_kind_e        kind_q, kind_d;
  logic [1:0]       cur_type_q, cur_type_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_value_q;
  logic [1:0]       out_kind_q;

  logic             in_xfer;
  logic             frame_end;
  logic [4:0]       dig;
  logic [1:0]       tt_type;
  logic             load_out;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign frame_end       = (s_axis_tdata_i == CH_END) || (wr_idx_q == POS_LAST);
  assign dig             = hex_digit(store_q[dig_idx_q]);
  assign tt_type         = store_q[4][1:0];
  assign load_out        = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d    = state_q;
    wr_idx_d   = wr_idx_q;
    dig_idx_d  = dig_idx_q;
    last_idx_d = last_idx_q;
    acc_d      = acc_q;
    kind_d     = kind_q;
    cur_type_d = cur_type_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (frame_end) begin
            wr_idx_d = '0;
            state_d  = ST_CHECK;
          end else begin
            wr_idx_d = wr_idx_q + IDX_W'(1);
          end
        end
      end
      ST_CHECK: begin
        state_d   = ST_IDLE;
        acc_d     = '0;
        dig_idx_d = POS_FIRST_DIGIT;
        if (store_q[0] == CH_START) begin
          if (store_q[1] == CH_S && store_q[2] == CH_P) begin
            if (store_q[11] == CH_END) begin
              kind_d     = KIND_SP;
              last_idx_d = POS_SP_LAST;
              state_d    = ST_HEX;
            end
          end else if (store_q[1] == CH_T && store_q[2] == CH_L) begin
            if (store_q[5] == CH_END) begin
              kind_d     = KIND_TL;
              last_idx_d = POS_TL_LAST;
              state_d    = ST_HEX;
            end
          end else if (store_q[1] == CH_T && store_q[2] == CH_T) begin
            // A trigger type equal to the one in force gives no result.
            if (store_q[5] == CH_END && store_q[3] == CH_ZERO &&
                store_q[4] >= CH_ZERO && store_q[4] <= CH_THREE &&
                tt_type != cur_type_q) begin
              kind_d     = KIND_TT;
              acc_d      = {30'd0, tt_type};
              cur_type_d = tt_type;
              state_d    = ST_EMIT;
            end
          end
        end
      end
      ST_HEX: begin
        if (!dig[4]) begin
          state_d = ST_IDLE;
        end else begin
          acc_d = {acc_q[27:0], dig[3:0]};
          if (dig_idx_q == last_idx_q) begin
            state_d = ST_EMIT;
          end else begin
            dig_idx_d = dig_idx_q + IDX_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_idx_q    <= '0;
      cur_type_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_idx_q    <= wr_idx_d;
      cur_type_q  <= cur_type_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The store keeps its contents across frames, so it is cleared by reset only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        store_q[i] <= 8'd0;
      end
    end else if (in_xfer) begin
      store_q[wr_idx_q] <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_idx_q  <= dig_idx_d;
    last_idx_q <= last_idx_d;
    acc_q      <= acc_d;
    kind_q     <= kind_d;
    if (load_out) begin
      out_value_q <= acc_q;
      out_kind_q  <= kind_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_kind_q;

  a_wr_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_idx_q <= POS_LAST)
    else $error("write index beyond the frame store");

  a_end_goes_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tdata_i == CH_END) |=> (state_q == ST_CHECK && wr_idx_q == '0))
    else $error("closing character did not start a frame check");

  a_hex_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HEX) |-> (dig_idx_q >= POS_FIRST_DIGIT && dig_idx_q <= last_idx_q))
    else $error("hex digit position outside the digit field");

  a_tt_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_TT) |-> (out_value_q[31:2] == 30'd0))
    else $error("trigger type result outside the type range");

  a_tl_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_TL) |-> (out_value_q[31:8] == 24'd0))
    else $error("trigger level result wider than one byte");

endmodule

`default_nettype wire
